@@ sv/ogcl_pkg.sv @@
// ogcl_pkg: shared types and constants for the occupancy grid cost lookup unit
// used by ogcl_cfg_regs, ogcl_ctrl, ogcl_datapath and the top level
`default_nettype none
package ogcl_pkg;

  localparam int MAX_SIDE   = 256;
  localparam int CELL_COUNT = MAX_SIDE * MAX_SIDE;
  localparam int CELL_AW    = $clog2(CELL_COUNT);
  localparam int COL_W      = $clog2(MAX_SIDE);
  localparam int SIDE_W     = COL_W + 1;

  localparam int DIV_W      = 32;
  localparam int DIV_CYCLES = DIV_W / 2;
  localparam int CNT_W      = $clog2(DIV_CYCLES);

  localparam logic [6:0] COST_FREE    = 7'd0;
  localparam logic [6:0] COST_MAX     = 7'd100;
  localparam logic [7:0] CELL_MAX_VAL = 8'd100;

  typedef enum logic [1:0] {
    KIND_QUERY = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    REG_ORIGIN_X   = 3'd0,
    REG_ORIGIN_Y   = 3'd1,
    REG_EXTENT_X   = 3'd2,
    REG_EXTENT_Y   = 3'd3,
    REG_RESOLUTION = 3'd4,
    REG_GRID_W     = 3'd5,
    REG_GRID_H     = 3'd6,
    REG_THRESHOLD  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] low_x;
    logic signed [31:0] low_y;
    logic [30:0]        extent_x;
    logic [30:0]        extent_y;
    logic [30:0]        resolution;
    logic [8:0]         grid_width;
    logic [8:0]         grid_height;
    logic [6:0]         cost_threshold;
  } cfg_t;

  typedef struct packed {
    logic load_point;
    logic wr_cell;
    logic clr_map;
    logic check;
    logic div_step;
    logic save_x;
    logic save_y;
    logic calc_addr;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic map_ready;
    logic out_of_bounds;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

@@ sv/occupancy_grid_cost_lookup_unit.sv @@
// occupancy_grid_cost_lookup_unit: top level of the occupancy grid cost lookup
// instantiates ogcl_cfg_regs, ogcl_ctrl and ogcl_datapath; types from ogcl_pkg
//
//   channel  direction  signals                  content
//   in_      slave      tvalid tready tdata tuser  write, clear or query item
//   out_     master     tvalid tready tdata        cost and blocked flag per query
//   cfg_     apb slave  psel penable pwrite paddr  eight 32-bit registers at 4*i
//
// write and clear items are taken in the idle state and may follow back to back
// a query goes from its bounds check straight to its result when no map is loaded or the point is out of
// bounds, else through two divisions on one shared 2-bit-per-cycle divider,
// then index, memory read and result steps; in_tready is low while a query runs
// the result waits in an output register; a query finishing before it is taken stalls
// reset is synchronous: registers to their defaults, map not ready; grid contents
// are undefined until written
`default_nettype none
module occupancy_grid_cost_lookup_unit (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [87:0]  in_tdata,   // point_x, point_y, cell_index, cell_value
  input  wire logic [1:0]   in_tuser,   // kind
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [7:0]        out_tdata,  // cost_percent, blocked
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [4:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  ogcl_pkg::cfg_t       cfg;
  ogcl_pkg::ctrl_cmd_t  cmd;
  ogcl_pkg::dp_status_t status;

  ogcl_cfg_regs u_cfg_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  ogcl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_kind   (in_tuser),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  ogcl_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .cmd           (cmd),
    .status        (status),
    .in_point_x    (in_tdata[31:0]),
    .in_point_y    (in_tdata[63:32]),
    .in_cell_index (in_tdata[79:64]),
    .in_cell_value (in_tdata[87:80]),
    .out_tready    (out_tready),
    .out_tvalid    (out_tvalid),
    .out_tdata     (out_tdata)
  );

endmodule
`default_nettype wire

@@ sv/ogcl_cfg_regs.sv @@
// ogcl_cfg_regs: apb-style configuration register file
// depends on ogcl_pkg for the register index codes and the cfg_t struct
`default_nettype none
module ogcl_cfg_regs (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [4:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready,
  output ogcl_pkg::cfg_t    cfg
);

  ogcl_pkg::cfg_t     cfg_r, cfg_nxt;
  ogcl_pkg::reg_idx_t idx;
  logic               wr_en;

  assign cfg_pready = 1'b1;
  assign idx        = ogcl_pkg::reg_idx_t'(cfg_paddr[4:2]);
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        ogcl_pkg::REG_ORIGIN_X:   cfg_nxt.low_x          = cfg_pwdata;
        ogcl_pkg::REG_ORIGIN_Y:   cfg_nxt.low_y          = cfg_pwdata;
        ogcl_pkg::REG_EXTENT_X:   cfg_nxt.extent_x       = cfg_pwdata[30:0];
        ogcl_pkg::REG_EXTENT_Y:   cfg_nxt.extent_y       = cfg_pwdata[30:0];
        ogcl_pkg::REG_RESOLUTION: cfg_nxt.resolution     = cfg_pwdata[30:0];
        ogcl_pkg::REG_GRID_W:     cfg_nxt.grid_width     = cfg_pwdata[8:0];
        ogcl_pkg::REG_GRID_H:     cfg_nxt.grid_height    = cfg_pwdata[8:0];
        ogcl_pkg::REG_THRESHOLD:  cfg_nxt.cost_threshold = cfg_pwdata[6:0];
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ogcl_pkg::REG_ORIGIN_X:   cfg_prdata = cfg_r.low_x;
      ogcl_pkg::REG_ORIGIN_Y:   cfg_prdata = cfg_r.low_y;
      ogcl_pkg::REG_EXTENT_X:   cfg_prdata = {1'b0, cfg_r.extent_x};
      ogcl_pkg::REG_EXTENT_Y:   cfg_prdata = {1'b0, cfg_r.extent_y};
      ogcl_pkg::REG_RESOLUTION: cfg_prdata = {1'b0, cfg_r.resolution};
      ogcl_pkg::REG_GRID_W:     cfg_prdata = {23'd0, cfg_r.grid_width};
      ogcl_pkg::REG_GRID_H:     cfg_prdata = {23'd0, cfg_r.grid_height};
      ogcl_pkg::REG_THRESHOLD:  cfg_prdata = {25'd0, cfg_r.cost_threshold};
      default:                  cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_x          <= 32'sd0;
      cfg_r.low_y          <= 32'sd0;
      cfg_r.extent_x       <= 31'd0;
      cfg_r.extent_y       <= 31'd0;
      cfg_r.resolution     <= 31'd65536;
      cfg_r.grid_width     <= 9'd256;
      cfg_r.grid_height    <= 9'd256;
      cfg_r.cost_threshold <= 7'd50;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

@@ sv/ogcl_ctrl.sv @@
// ogcl_ctrl: sequencing state machine for writes, clears and point queries
// depends on ogcl_pkg for the command and status structs
`default_nettype none
module ogcl_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  input  wire logic [1:0]           in_kind,
  output logic                      in_tready,
  input  wire ogcl_pkg::dp_status_t status,
  output ogcl_pkg::ctrl_cmd_t       cmd
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_CHECK  = 9'b000000010,
    S_DIVX   = 9'b000000100,
    S_SAVEX  = 9'b000001000,
    S_DIVY   = 9'b000010000,
    S_SAVEY  = 9'b000100000,
    S_ADDR   = 9'b001000000,
    S_READ   = 9'b010000000,
    S_RESULT = 9'b100000000
  } state_t;

  localparam logic [ogcl_pkg::CNT_W-1:0] CNT_LAST =
    ogcl_pkg::CNT_W'(ogcl_pkg::DIV_CYCLES - 1);

  state_t                      state_r, state_nxt;
  logic [ogcl_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                        accept;
  ogcl_pkg::kind_t             kind;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid & in_tready;
  assign kind      = ogcl_pkg::kind_t'(in_kind);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (kind)
            ogcl_pkg::KIND_QUERY: begin
              cmd.load_point = 1'b1;
              state_nxt      = S_CHECK;
            end
            ogcl_pkg::KIND_WRITE: cmd.wr_cell = 1'b1;
            ogcl_pkg::KIND_CLEAR: cmd.clr_map = 1'b1;
            default: ;
          endcase
        end
      end
      S_CHECK: begin
        // also loads the divider with the x offset
        cmd.check = 1'b1;
        cnt_nxt   = '0;
        if (!status.map_ready || status.out_of_bounds) begin
          state_nxt = S_RESULT;
        end else begin
          state_nxt = S_DIVX;
        end
      end
      S_DIVX: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_SAVEX;
        end
      end
      S_SAVEX: begin
        cmd.save_x = 1'b1;
        cnt_nxt    = '0;
        state_nxt  = S_DIVY;
      end
      S_DIVY: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_SAVEY;
        end
      end
      S_SAVEY: begin
        cmd.save_y = 1'b1;
        state_nxt  = S_ADDR;
      end
      S_ADDR: begin
        cmd.calc_addr = 1'b1;
        state_nxt     = S_READ;
      end
      S_READ: state_nxt = S_RESULT;
      S_RESULT: begin
        // wait here while the previous result has not been taken
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

@@ sv/ogcl_datapath.sv @@
// ogcl_datapath: bounds check, shared radix-4 divider, grid memory and result register
// depends on ogcl_pkg; driven by ogcl_ctrl through ctrl_cmd_t
`default_nettype none
module ogcl_datapath (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire ogcl_pkg::cfg_t       cfg,
  input  wire ogcl_pkg::ctrl_cmd_t  cmd,
  output ogcl_pkg::dp_status_t      status,
  input  wire logic signed [31:0]   in_point_x,
  input  wire logic signed [31:0]   in_point_y,
  input  wire logic [15:0]          in_cell_index,
  input  wire logic signed [7:0]    in_cell_value,
  input  wire logic                 out_tready,
  output logic                      out_tvalid,
  output logic [7:0]                out_tdata
);

  localparam int CW = ogcl_pkg::COL_W;
  localparam int SW = ogcl_pkg::SIDE_W;
  localparam int DW = ogcl_pkg::DIV_W;
  localparam int AW = ogcl_pkg::CELL_AW;

  logic [7:0] grid_mem [ogcl_pkg::CELL_COUNT];

  logic signed [31:0] px_r, py_r;
  logic [30:0]        off_y_r;
  logic               nomap_r, oob_r;
  logic               map_ready_r, map_ready_nxt;
  logic [DW-1:0]      rem_r, rem_nxt;
  logic [DW-1:0]      quo_r, quo_nxt;
  logic [CW-1:0]      gx_r, gy_r;
  logic [AW-1:0]      idx_r;
  logic [7:0]         rd_r;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_data_r;

  // bounds check, inclusive on both ends
  logic signed [33:0] px_e, py_e, ox_e, oy_e, hx_e, hy_e;
  logic signed [33:0] dx_e, dy_e;
  logic               oob;

  assign px_e = 34'(px_r);
  assign py_e = 34'(py_r);
  assign ox_e = 34'(cfg.low_x);
  assign oy_e = 34'(cfg.low_y);
  assign hx_e = ox_e + $signed({3'b000, cfg.extent_x});
  assign hy_e = oy_e + $signed({3'b000, cfg.extent_y});
  assign dx_e = px_e - ox_e;
  assign dy_e = py_e - oy_e;
  assign oob  = (px_e < ox_e) || (px_e > hx_e) || (py_e < oy_e) || (py_e > hy_e);

  // used side lengths, clamped to 1..MAX_SIDE, kept as side-1
  logic [CW-1:0] wm1, hm1;
  logic [SW-1:0] w_used;

  always_comb begin
    if (cfg.grid_width == '0) begin
      wm1 = '0;
    end else if (cfg.grid_width > SW'(ogcl_pkg::MAX_SIDE)) begin
      wm1 = '1;
    end else begin
      wm1 = CW'(cfg.grid_width - 1'b1);
    end
    if (cfg.grid_height == '0) begin
      hm1 = '0;
    end else if (cfg.grid_height > SW'(ogcl_pkg::MAX_SIDE)) begin
      hm1 = '1;
    end else begin
      hm1 = CW'(cfg.grid_height - 1'b1);
    end
  end

  assign w_used = {1'b0, wm1} + 1'b1;

  // restoring divider, two quotient bits per cycle
  logic [DW+1:0] t1, t2;
  logic [DW-1:0] r1, r2;
  logic          neg1, neg2;

  always_comb begin
    t1   = {1'b0, rem_r, quo_r[DW-1]} - {3'b000, cfg.resolution};
    neg1 = t1[DW+1];
    r1   = neg1 ? {rem_r[DW-2:0], quo_r[DW-1]} : t1[DW-1:0];
    t2   = {1'b0, r1, quo_r[DW-2]} - {3'b000, cfg.resolution};
    neg2 = t2[DW+1];
    r2   = neg2 ? {r1[DW-2:0], quo_r[DW-2]} : t2[DW-1:0];
  end

  // quotient clamped to the last column or row
  logic [CW-1:0] qx_clamp, qy_clamp;
  assign qx_clamp = (quo_r > DW'(wm1)) ? wm1 : quo_r[CW-1:0];
  assign qy_clamp = (quo_r > DW'(hm1)) ? hm1 : quo_r[CW-1:0];

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    if (cmd.check) begin
      rem_nxt = '0;
      quo_nxt = {1'b0, dx_e[30:0]};
    end else if (cmd.save_x) begin
      rem_nxt = '0;
      quo_nxt = {1'b0, off_y_r};
    end else if (cmd.div_step) begin
      rem_nxt = r2;
      quo_nxt = {quo_r[DW-3:0], ~neg1, ~neg2};
    end
  end

  // cell to cost
  logic [6:0] cell_cost, res_cost;
  logic       res_blocked;

  always_comb begin
    priority if (rd_r[7]) begin
      cell_cost = ogcl_pkg::COST_FREE;
    end else if (rd_r > ogcl_pkg::CELL_MAX_VAL) begin
      cell_cost = ogcl_pkg::COST_MAX;
    end else begin
      cell_cost = rd_r[6:0];
    end
    // with a map loaded, a point out of bounds is blocked whatever the threshold
    priority if (nomap_r) begin
      res_cost    = ogcl_pkg::COST_FREE;
      res_blocked = 1'b0;
    end else if (oob_r) begin
      res_cost    = ogcl_pkg::COST_MAX;
      res_blocked = 1'b1;
    end else begin
      res_cost    = cell_cost;
      res_blocked = (cell_cost > cfg.cost_threshold);
    end
  end

  always_comb begin
    map_ready_nxt = map_ready_r;
    if (cmd.wr_cell) begin
      map_ready_nxt = 1'b1;
    end else if (cmd.clr_map) begin
      map_ready_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign status.map_ready     = map_ready_r;
  assign status.out_of_bounds = oob;
  assign status.out_free      = !out_valid_r || out_tready;
  assign out_tvalid           = out_valid_r;
  assign out_tdata            = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_ready_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      map_ready_r <= map_ready_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (cmd.load_point) begin
      px_r <= in_point_x;
      py_r <= in_point_y;
    end
    if (cmd.check) begin
      nomap_r <= !map_ready_r;
      oob_r   <= oob;
      off_y_r <= dy_e[30:0];
    end
    if (cmd.save_x) begin
      gx_r <= qx_clamp;
    end
    if (cmd.save_y) begin
      gy_r <= qy_clamp;
    end
    if (cmd.calc_addr) begin
      idx_r <= AW'(gx_r) + AW'(w_used) * AW'(gy_r);
    end
    if (cmd.out_load) begin
      out_data_r <= {res_blocked, res_cost};
    end
  end

  // grid store: written by write items, read during a query
  always_ff @(posedge clk) begin
    if (cmd.wr_cell) begin
      grid_mem[in_cell_index[AW-1:0]] <= in_cell_value;
    end
    rd_r <= grid_mem[idx_r];
  end

endmodule
`default_nettype wire

@@ sim/ogcl_checker.sv @@
// ogcl_checker: predicts the cost result of every query sent to the grid lookup unit
// and compares it with each result transfer; tracks register writes on the apb port
// depends on ogcl_pkg for the item kinds, register indexes and grid sizes
module ogcl_checker
  import ogcl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [87:0] in_tdata,
  input  wire logic [1:0]  in_tuser,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [7:0]  out_tdata,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  input  wire logic        cfg_pready,
  output int               mismatch_total,
  output int               costs_due
);

  // blocked sits in the top bit of out_tdata
  typedef struct packed {
    logic       blocked;
    logic [6:0] cost;
  } cost_t;

  logic signed [31:0] org_x, org_y;
  logic [30:0]        ext_x, ext_y, res;
  logic [8:0]         cols, rows;
  logic [6:0]         thr;
  logic               map_loaded;
  logic [7:0]         grid [0:CELL_COUNT-1];
  cost_t              due_costs [$];
  int                 results_seen;

  initial begin
    mismatch_total = 0;
    costs_due      = 0;
    results_seen   = 0;
  end

  function automatic longint unsigned usable_side(logic [8:0] n);
    if (n == 0) return 1;
    if (n > MAX_SIDE) return MAX_SIDE;
    return n;
  endfunction

  function automatic longint unsigned grid_coord(longint unsigned off, longint unsigned side);
    longint unsigned q;
    // zero resolution saturates the quotient
    if (res == 0) q = side - 1;
    else q = off / res;
    if (q > side - 1) q = side - 1;
    return q;
  endfunction

  function automatic cost_t lookup_cost(logic [31:0] px_bits, logic [31:0] py_bits);
    cost_t              r;
    longint             px, py, ox, oy;
    longint unsigned    w, h, gx, gy;
    logic signed [7:0]  stored;
    r.cost    = COST_FREE;
    r.blocked = 1'b0;
    if (!map_loaded) return r;
    px = $signed(px_bits);
    py = $signed(py_bits);
    ox = org_x;
    oy = org_y;
    // inclusive bounds at full precision
    if (px < ox || px > ox + longint'(ext_x) || py < oy || py > oy + longint'(ext_y)) begin
      r.cost    = COST_MAX;
      r.blocked = 1'b1;
      return r;
    end
    w  = usable_side(cols);
    h  = usable_side(rows);
    gx = grid_coord(px - ox, w);
    gy = grid_coord(py - oy, h);
    stored = grid[gx + w * gy];
    if (stored < 0) r.cost = COST_FREE;
    else if (int'(stored) > int'(COST_MAX)) r.cost = COST_MAX;
    else r.cost = stored[6:0];
    r.blocked = r.cost > thr;
    return r;
  endfunction

  always @(posedge clk) begin
    cost_t got;
    cost_t want;
    if (!rst_n) begin
      org_x      = '0;
      org_y      = '0;
      ext_x      = '0;
      ext_y      = '0;
      res        = 31'd65536;
      cols       = 9'd256;
      rows       = 9'd256;
      thr        = 7'd50;
      map_loaded = 1'b0;
      due_costs.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (reg_idx_t'(cfg_paddr[4:2]))
          REG_ORIGIN_X:   org_x = cfg_pwdata;
          REG_ORIGIN_Y:   org_y = cfg_pwdata;
          REG_EXTENT_X:   ext_x = cfg_pwdata[30:0];
          REG_EXTENT_Y:   ext_y = cfg_pwdata[30:0];
          REG_RESOLUTION: res   = cfg_pwdata[30:0];
          REG_GRID_W:     cols  = cfg_pwdata[8:0];
          REG_GRID_H:     rows  = cfg_pwdata[8:0];
          REG_THRESHOLD:  thr   = cfg_pwdata[6:0];
          default: ;
        endcase
      end
      // results first, so a spurious one never consumes a cost queued at this edge
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        results_seen++;
        if (due_costs.size() == 0) begin
          mismatch_total++;
          if (mismatch_total <= 10)
            $display("result %0d with no query outstanding: cost %0d blocked %0b",
                     results_seen, got.cost, got.blocked);
        end else begin
          want = due_costs.pop_front();
          if (got.cost !== want.cost || got.blocked !== want.blocked) begin
            mismatch_total++;
            if (mismatch_total <= 10)
              $display("result %0d: cost %0d blocked %0b, expected cost %0d blocked %0b",
                       results_seen, got.cost, got.blocked, want.cost, want.blocked);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        case (kind_t'(in_tuser))
          KIND_WRITE: begin
            grid[in_tdata[79:64]] = in_tdata[87:80];
            map_loaded = 1'b1;
          end
          KIND_CLEAR: map_loaded = 1'b0;
          KIND_QUERY: due_costs.push_back(lookup_cost(in_tdata[31:0], in_tdata[63:32]));
          default: ;
        endcase
      end
    end
    costs_due = due_costs.size();
  end

endmodule

@@ sim/tb.sv @@
// tb: stimulus and verdict for occupancy_grid_cost_lookup_unit
// preloads the grid, runs directed and random traffic over several register setups;
// ogcl_checker does the prediction and comparison; types from ogcl_pkg
module tb;
  import ogcl_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 6;
  localparam int DRAIN_CYCLES  = 45;
  localparam int STALL_LIMIT   = 4000;
  localparam int HOLD_CYCLES   = 300;
  localparam int ITEMS_PER_SET = 95;
  localparam int SETUP_COUNT   = 7;
  // every setup keeps columns times rows within the preloaded cells
  localparam int PRELOAD_CELLS = 256;

  typedef struct packed {
    logic [31:0] ox;
    logic [31:0] oy;
    logic [30:0] ex;
    logic [30:0] ey;
    logic [30:0] res;
    logic [8:0]  cols;
    logic [8:0]  rows;
    logic [6:0]  thr;
  } map_setup_t;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [87:0] in_tdata    = '0;   // point_x, point_y, cell_index, cell_value
  logic [1:0]  in_tuser    = KIND_QUERY;  // kind
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [7:0]  out_tdata;          // cost_percent, blocked
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [4:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int         send_idle_pct  = 0;
  int         recv_stall_pct = 0;
  bit         hold_req       = 1'b0;
  bit         hold_done      = 1'b0;
  int         hold_count     = 0;
  int         idle_cycles    = 0;
  int         n_query = 0, n_write = 0, n_clear = 0, n_other = 0;
  int         bad_count;
  int         outstanding;
  map_setup_t current;

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  occupancy_grid_cost_lookup_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  ogcl_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_pready     (cfg_pready),
    .mismatch_total (bad_count),
    .costs_due      (outstanding)
  );

  // result side: random stalls, plus one long hold-off so the unit backs up
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      out_tready = 1'b0;
      hold_count++;
      if (hold_count >= HOLD_CYCLES) hold_done = 1'b1;
    end else begin
      out_tready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("no transfer for %0d cycles, giving up", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_item(kind_t k, logic [31:0] px, logic [31:0] py,
                           logic [15:0] idx, logic [7:0] val);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_tuser  = k;
    in_tdata  = {val, idx, py, px};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    in_tvalid = 1'b0;
    case (k)
      KIND_QUERY: n_query++;
      KIND_WRITE: n_write++;
      KIND_CLEAR: n_clear++;
      default:    n_other++;
    endcase
  endtask

  task automatic send_query(logic [31:0] px, logic [31:0] py);
    send_item(KIND_QUERY, px, py, 16'($urandom), 8'($urandom));
  endtask

  task automatic send_write(logic [15:0] idx, logic [7:0] val);
    send_item(KIND_WRITE, $urandom, $urandom, idx, val);
  endtask

  task automatic send_clear();
    send_item(KIND_CLEAR, $urandom, $urandom, 16'($urandom), 8'($urandom));
  endtask

  task automatic send_unused();
    send_item(KIND_NONE, $urandom, $urandom, 16'($urandom), 8'($urandom));
  endtask

  task automatic write_reg(reg_idx_t r, logic [31:0] v);
    cfg_paddr   = {r, 2'b00};
    cfg_pwdata  = v;
    cfg_pwrite  = 1'b1;
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  // writes and clears give no result, so allow a full query time after the last one
  task automatic load_setup(map_setup_t s);
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    write_reg(REG_ORIGIN_X, s.ox);
    write_reg(REG_ORIGIN_Y, s.oy);
    write_reg(REG_EXTENT_X, {1'b0, s.ex});
    write_reg(REG_EXTENT_Y, {1'b0, s.ey});
    write_reg(REG_RESOLUTION, {1'b0, s.res});
    write_reg(REG_GRID_W, {23'd0, s.cols});
    write_reg(REG_GRID_H, {23'd0, s.rows});
    write_reg(REG_THRESHOLD, {25'd0, s.thr});
    current = s;
  endtask

  function automatic logic [7:0] random_cell_value();
    if ($urandom_range(7) == 0) return 8'($urandom);
    return 8'($urandom_range(101) - 1);
  endfunction

  // mostly inside the map, some on or just beyond the bounds, some anywhere
  function automatic logic [31:0] pick_coord(logic [31:0] o, logic [30:0] e);
    longint base;
    longint v;
    int     r;
    base = $signed(o);
    r    = $urandom_range(99);
    if (r < 10) begin
      v = $urandom;
    end else if (r < 25) begin
      case ($urandom_range(3))
        0:       v = base - 1;
        1:       v = base;
        2:       v = base + e;
        default: v = base + e + 1;
      endcase
    end else begin
      v = base + longint'($urandom_range(e));
    end
    return v[31:0];
  endfunction

  task automatic random_item();
    int r;
    r = $urandom_range(99);
    if (r < 72) send_query(pick_coord(current.ox, current.ex), pick_coord(current.oy, current.ey));
    else if (r < 95) send_write(16'($urandom_range(299)), random_cell_value());
    else if (r < 98) send_clear();
    else send_unused();
  endtask

  initial begin
    map_setup_t setups [SETUP_COUNT];
    logic [7:0] v;
    setups[0] = '{ox: 32'd0, oy: 32'd0, ex: 31'(16 * 65536), ey: 31'(16 * 65536),
                  res: 31'd65536, cols: 9'd16, rows: 9'd16, thr: 7'd50};
    setups[1] = '{ox: 32'(-100 * 65536), oy: 32'(-50 * 65536), ex: 31'(20 * 65536),
                  ey: 31'(30 * 65536), res: 31'd16384, cols: 9'd16, rows: 9'd8, thr: 7'd0};
    setups[2] = '{ox: 32'h8000_0000, oy: 32'h8000_0000, ex: 31'h7FFF_FFFF,
                  ey: 31'h7FFF_FFFF, res: 31'h7FFF_FFFF, cols: 9'd1, rows: 9'd1,
                  thr: 7'd100};
    // zero resolution, oversize and zero grid sides, threshold above any cost
    setups[3] = '{ox: 32'h7FFF_FFFF, oy: 32'h7FFF_F000, ex: 31'h7FFF_FFFF, ey: 31'd4096,
                  res: 31'd0, cols: 9'h1FF, rows: 9'd0, thr: 7'h7F};
    setups[4] = '{ox: 32'd12345, oy: 32'(-777), ex: 31'(5 * 65536), ey: 31'(7 * 65536),
                  res: 31'd1, cols: 9'd300, rows: 9'd1, thr: 7'd99};
    for (int s = 5; s < SETUP_COUNT; s++)
      setups[s] = '{ox: $urandom, oy: $urandom, ex: 31'($urandom >> $urandom_range(31)),
                    ey: 31'($urandom >> $urandom_range(31)),
                    res: 31'($urandom >> $urandom_range(31)),
                    cols: 9'($urandom_range(16)), rows: 9'($urandom_range(16)),
                    thr: 7'($urandom)};

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    // nothing loaded yet
    send_query(32'd0, 32'd0);
    send_unused();
    send_clear();
    send_query(32'h0001_0000, 32'hFFFF_FFFF);

    // fill every cell that a query can reach
    for (int i = 0; i < PRELOAD_CELLS; i++) begin
      case (i)
        0:       v = 8'hFF;
        1:       v = 8'd100;
        2:       v = 8'd127;
        3:       v = 8'h80;
        4:       v = 8'd101;
        5:       v = 8'd50;
        6:       v = 8'd51;
        default: v = random_cell_value();
      endcase
      send_write(16'(i), v);
    end

    load_setup(setups[0]);
    send_query(32'd0, 32'd0);
    send_query(32'(1 * 65536), 32'd0);
    send_query(32'(2 * 65536), 32'd0);
    send_query(32'(3 * 65536), 32'd0);
    send_query(32'(4 * 65536), 32'd0);
    send_query(32'(5 * 65536), 32'd0);
    send_query(32'(6 * 65536), 32'd0);
    send_query(32'(16 * 65536), 32'(16 * 65536));
    send_query(32'(256 * 65536), 32'(256 * 65536));
    send_query(32'hFFFF_FFFF, 32'd0);
    send_query(32'd0, 32'hFFFF_FFFF);
    send_query(32'(16 * 65536 + 1), 32'd0);
    send_query(32'd0, 32'(16 * 65536 + 1));
    send_query(32'h8000_0000, 32'h7FFF_FFFF);
    send_query(32'h7FFF_FFFF, 32'h8000_0000);
    send_clear();
    send_query(32'(1 * 65536), 32'd0);
    send_unused();
    send_query(32'(1 * 65536), 32'd0);
    send_write(16'd7, 8'hAA);
    send_query(32'(7 * 65536), 32'd0);
    send_write(16'hFFFF, 8'h55);
    send_query(32'(16 * 65536), 32'(15 * 65536 + 32768));

    for (int p = 0; p < SETUP_COUNT; p++) begin
      load_setup(setups[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      for (int i = 0; i < ITEMS_PER_SET; i++) begin
        if (p == 0 && i == 40) hold_req = 1'b1;
        random_item();
      end
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("sent %0d queries, %0d cell writes, %0d clears, %0d unused-kind items",
             n_query, n_write, n_clear, n_other);
    $display("%0d register setups incl. zero resolution, clamped sides, four idling phases",
             SETUP_COUNT);
    if (bad_count == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      if (outstanding != 0) $display("%0d expected results never arrived", outstanding);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
